@@ hw/rtl/air_pkg.sv @@
// shared types and constants of the aligned interval register allocator
// no dependencies

package air_pkg;

    localparam int ACTIVE_ENTRIES = 64;
    localparam int POS_BITS       = 16;
    localparam int REG_FILE_SIZE  = 512;

    localparam int SLOT_W     = $clog2(ACTIVE_ENTRIES);
    localparam int IDENT_W    = 16;
    localparam int POS_W      = 16;
    localparam int SPAN_W     = 10;
    localparam int BASE_W     = 9;
    localparam int FOOT_W     = 10;
    localparam int LIMIT_W    = 10;
    localparam int CAND_W     = BASE_W + 2;
    localparam int SUM_W      = BASE_W + 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDX_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_CAND  = 1'd1;

    // result status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_NOROOM   = 2'd1;
    localparam logic [1:0] ST_SKIPPED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic               first_item;
        logic               last_item;
        logic [IDENT_W-1:0] set_ident;
        logic [POS_W-1:0]   live_start;
        logic [POS_W-1:0]   live_end;
        logic [SPAN_W-1:0]  span;
        logic               pinned;
        logic [BASE_W-1:0]  pinned_base;
    } air_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BASE_W-1:0] placed_base;
        logic [FOOT_W-1:0] peak_footprint;
        logic              run_ok;
        logic              run_done;
    } air_out_t;

    // span rounded up to a power of two, at least one
    function automatic logic [CAND_W-1:0] align_of(input logic [SPAN_W-1:0] span);
        logic [CAND_W-1:0] a;
        a = '0;
        for (int k = SPAN_W; k >= 0; k--) begin
            if ({1'b0, span} <= (CAND_W'(1) << k)) begin
                a = CAND_W'(1) << k;
            end
        end
        return a;
    endfunction

endpackage

@@ hw/rtl/aligned_interval_register_allocator.sv @@
// aligned interval register allocator, top level
// depends on air_pkg

// usage
// - input channel s_valid/s_ready/s_data carries one live interval per word,
//   in order of start position; first_item opens a new run
// - result channel m_valid/m_ready/m_data returns one word per interval:
//   status, assigned base, peak footprint, run_ok and run_done
// - cfg_wr_en/cfg_idx/cfg_wdata write reg_limit (index 0) and
//   candidate_set (index 1); write only while the block is idle
// - an interval passes from accept to result through an expiry step, a
//   search that tries one candidate base per step and a commit step that
//   loads the result register; at most one base is tried for pinned
//   intervals and at most limit / align + 1 otherwise, with the limit
//   saturated at 512; an interval after a failure goes from expiry to commit
// - the commit returns the block to idle, so the next word can be taken
//   while that result is still on m_data
// - the search is a single overlap checker comparing one candidate base
//   against all active entries at once, stepped by the aligned stride
// - one interval is in flight at a time; s_ready is high only while idle
// - the result register lets a new word be accepted while the previous
//   result still waits; if the receiver stalls, the commit cycle waits
//   until the result register is free
// - reset clears the active table valid bits, footprint, flags and the
//   result valid, and restores reg_limit to 256 and candidate_set to 0

module aligned_interval_register_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  air_pkg::air_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output air_pkg::air_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [air_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [air_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPIRE,
        S_SEARCH,
        S_PLACE
    } state_t;

    state_t                          state_reg;
    logic [air_pkg::LIMIT_W-1:0]     limit_cfg_reg;
    logic [air_pkg::IDENT_W-1:0]     cand_set_reg;

    // active table: valid bits reset, payload written before use
    logic [air_pkg::ACTIVE_ENTRIES-1:0] act_valid_reg;
    logic [air_pkg::BASE_W-1:0]   act_base_reg [air_pkg::ACTIVE_ENTRIES];
    logic [air_pkg::SPAN_W-1:0]   act_span_reg [air_pkg::ACTIVE_ENTRIES];
    logic [air_pkg::POS_BITS-1:0] act_end_reg  [air_pkg::ACTIVE_ENTRIES];

    logic [air_pkg::FOOT_W-1:0]   foot_reg;
    logic                         failed_reg;
    logic                         cplaced_reg;

    // current interval and search state
    air_pkg::air_in_t             item_reg;
    logic [air_pkg::CAND_W-1:0]   cand_reg;
    logic [air_pkg::CAND_W-1:0]   align_reg;
    logic [air_pkg::LIMIT_W-1:0]  max_base_reg;
    logic                         fit_reg;
    logic [1:0]                   stat_reg;

    logic                         m_valid_reg;
    air_pkg::air_out_t            m_data_reg;

    // combinational helpers
    logic [air_pkg::LIMIT_W-1:0]  limit_eff;
    logic                         blocked;
    logic                         free_any;
    logic [air_pkg::SLOT_W-1:0]   free_slot;
    logic                         out_free;
    logic                         commit;
    logic [1:0]                   stat_fin;
    logic [air_pkg::SUM_W-1:0]    place_end;
    logic [air_pkg::FOOT_W-1:0]   foot_next;
    logic                         failed_next;
    logic                         cplaced_next;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // limit saturates at the register file size
    assign limit_eff = (limit_cfg_reg > air_pkg::LIMIT_W'(air_pkg::REG_FILE_SIZE))
                     ? air_pkg::LIMIT_W'(air_pkg::REG_FILE_SIZE) : limit_cfg_reg;

    // shared overlap checker: candidate base against every active entry
    always_comb begin
        logic [air_pkg::SUM_W-1:0] cand_hi;
        logic [air_pkg::SUM_W-1:0] ent_hi;
        blocked = 1'b0;
        cand_hi = air_pkg::SUM_W'(cand_reg) + air_pkg::SUM_W'(item_reg.span);
        for (int i = 0; i < air_pkg::ACTIVE_ENTRIES; i++) begin
            ent_hi = air_pkg::SUM_W'(act_base_reg[i]) + air_pkg::SUM_W'(act_span_reg[i]);
            if (act_valid_reg[i]
                && (air_pkg::SUM_W'(cand_reg) < ent_hi)
                && (air_pkg::SUM_W'(act_base_reg[i]) < cand_hi)) begin
                blocked = 1'b1;
            end
        end
    end

    // lowest free entry
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = air_pkg::ACTIVE_ENTRIES - 1; i >= 0; i--) begin
            if (!act_valid_reg[i]) begin
                free_any  = 1'b1;
                free_slot = air_pkg::SLOT_W'(i);
            end
        end
    end

    // commit stage results
    always_comb begin
        stat_fin = stat_reg;
        if (stat_reg == air_pkg::ST_PLACED && !free_any) begin
            stat_fin = air_pkg::ST_OVERFLOW;
        end
        commit = (state_reg == S_PLACE) && out_free && (stat_fin == air_pkg::ST_PLACED);
        place_end = air_pkg::SUM_W'(cand_reg) + air_pkg::SUM_W'(item_reg.span);
        foot_next = foot_reg;
        if (commit && place_end > air_pkg::SUM_W'(foot_reg)) begin
            foot_next = place_end[air_pkg::FOOT_W-1:0];
        end
        failed_next = failed_reg
                   || (stat_fin == air_pkg::ST_NOROOM)
                   || (stat_fin == air_pkg::ST_OVERFLOW);
        cplaced_next = cplaced_reg || (commit && item_reg.set_ident == cand_set_reg);
    end

    // sequencer, flags and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            limit_cfg_reg <= air_pkg::LIMIT_W'(256);
            cand_set_reg  <= '0;
            act_valid_reg <= '0;
            foot_reg      <= '0;
            failed_reg    <= 1'b0;
            cplaced_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_idx == air_pkg::REG_IDX_LIMIT) begin
                    limit_cfg_reg <= cfg_wdata[air_pkg::LIMIT_W-1:0];
                end else begin
                    cand_set_reg <= cfg_wdata[air_pkg::IDENT_W-1:0];
                end
            end
            // the commit cycle reloads the result register itself
            if (m_valid_reg && m_ready && state_reg != S_PLACE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        if (s_data.first_item) begin
                            act_valid_reg <= '0;
                            foot_reg      <= '0;
                            failed_reg    <= 1'b0;
                            cplaced_reg   <= 1'b0;
                        end
                        state_reg <= S_EXPIRE;
                    end
                end
                S_EXPIRE: begin
                    if (failed_reg) begin
                        stat_reg  <= air_pkg::ST_SKIPPED;
                        state_reg <= S_PLACE;
                    end else begin
                        // drop every entry whose end lies below the new start
                        for (int i = 0; i < air_pkg::ACTIVE_ENTRIES; i++) begin
                            if (act_end_reg[i] < item_reg.live_start[air_pkg::POS_BITS-1:0]) begin
                                act_valid_reg[i] <= 1'b0;
                            end
                        end
                        cand_reg     <= item_reg.pinned
                                      ? air_pkg::CAND_W'(item_reg.pinned_base) : '0;
                        align_reg    <= air_pkg::align_of(item_reg.span);
                        fit_reg      <= (item_reg.span <= limit_eff);
                        max_base_reg <= limit_eff - item_reg.span;
                        state_reg    <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // one candidate base per cycle
                    if (!fit_reg || cand_reg > air_pkg::CAND_W'(max_base_reg)) begin
                        stat_reg  <= air_pkg::ST_NOROOM;
                        state_reg <= S_PLACE;
                    end else if (!blocked) begin
                        stat_reg  <= air_pkg::ST_PLACED;
                        state_reg <= S_PLACE;
                    end else if (item_reg.pinned) begin
                        stat_reg  <= air_pkg::ST_NOROOM;
                        state_reg <= S_PLACE;
                    end else begin
                        cand_reg <= cand_reg + align_reg;
                    end
                end
                S_PLACE: begin
                    if (out_free) begin
                        if (commit) begin
                            act_valid_reg[free_slot] <= 1'b1;
                        end
                        foot_reg    <= foot_next;
                        failed_reg  <= failed_next;
                        cplaced_reg <= cplaced_next;
                        m_valid_reg <= 1'b1;
                        m_data_reg.status         <= stat_fin;
                        m_data_reg.placed_base    <= (stat_fin == air_pkg::ST_PLACED)
                                                   ? cand_reg[air_pkg::BASE_W-1:0] : '0;
                        m_data_reg.peak_footprint <= foot_next;
                        m_data_reg.run_ok         <= item_reg.last_item && !failed_next
                                                   && cplaced_next;
                        m_data_reg.run_done       <= item_reg.last_item;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // active table payload
    always_ff @(posedge aclk) begin
        if (commit) begin
            act_base_reg[free_slot] <= cand_reg[air_pkg::BASE_W-1:0];
            act_span_reg[free_slot] <= item_reg.span;
            act_end_reg[free_slot]  <= item_reg.live_end[air_pkg::POS_BITS-1:0];
        end
    end

`ifndef SYNTHESIS
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_PLACE))
        else $error("result appeared outside the commit cycle");

    a_base_zero_unplaced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != air_pkg::ST_PLACED)
        |-> (m_data_reg.placed_base == '0))
        else $error("nonzero base on a failed interval");

    a_footprint_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        foot_reg <= air_pkg::FOOT_W'(air_pkg::REG_FILE_SIZE))
        else $error("footprint beyond register file");

    a_run_ok_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.run_ok) |-> m_data_reg.run_done)
        else $error("run_ok without run_done");

    a_commit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (place_end <= air_pkg::SUM_W'(limit_eff)))
        else $error("placement runs past the limit");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the aligned interval register allocator
// depends on air_pkg and aligned_interval_register_allocator

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import air_pkg::*;

    // cycles with no handshake on either channel before the run is given up
    localparam int STALL_LIMIT  = 20000;
    // time after the last result, sized for the worst search plus expiry and commit
    localparam int DRAIN_CYCLES = 600;
    localparam int PHASES       = 9;
    localparam int PHASE_WORDS  = 234;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    air_in_t   s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    air_out_t  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    aligned_interval_register_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // intervals waiting to be driven, and results predicted for accepted ones
    air_in_t  interval_q[$];
    air_out_t placement_q[$];

    // append one interval to the pending queue
    function automatic void add_interval(input air_in_t w);
        interval_q.insert(interval_q.size(), w);
    endfunction

    // idle percentages of the sender and the receiver, changed per phase
    int send_idle_pct = 15;
    int recv_idle_pct = 83;

    // our own copy of the register settings
    int          cfg_limit = 256;
    logic [15:0] cfg_cand  = '0;

    // our own copy of the allocator state: active table, footprint, flags
    bit tbl_valid[ACTIVE_ENTRIES];
    int tbl_base[ACTIVE_ENTRIES];
    int tbl_span[ACTIVE_ENTRIES];
    int tbl_end[ACTIVE_ENTRIES];
    int peak_regs  = 0;
    bit run_failed = 1'b0;
    bit cand_seen  = 1'b0;

    // bookkeeping for the end of the run
    int mismatches    = 0;
    int words_checked = 0;
    int status_tally[4];
    int runs_closed   = 0;
    int runs_ok       = 0;
    int settings_used = 0;
    int stall_cycles  = 0;

    // does [base, base+span) touch any live entry
    function automatic bit overlaps(input int base, input int span);
        for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
            if (tbl_valid[i] && base < tbl_base[i] + tbl_span[i] &&
                tbl_base[i] < base + span) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // expire, search, commit: returns the result word the block should give
    function automatic air_out_t place_interval(input air_in_t w);
        air_out_t r;
        int lim, span, base, align, slot;
        bit found;
        lim   = (cfg_limit > REG_FILE_SIZE) ? REG_FILE_SIZE : cfg_limit;
        span  = int'(w.span);
        base  = 0;
        found = 1'b0;
        slot  = -1;
        r     = '0;
        if (w.first_item) begin
            for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
            end
            peak_regs  = 0;
            run_failed = 1'b0;
            cand_seen  = 1'b0;
        end
        if (run_failed) begin
            // sticky failure: no expiry, no placement
            r.status = ST_SKIPPED;
        end else begin
            for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
                if (tbl_valid[i] && tbl_end[i] < int'(w.live_start)) begin
                    tbl_valid[i] = 1'b0;
                end
            end
            if (w.pinned) begin
                if (int'(w.pinned_base) + span <= lim &&
                    !overlaps(int'(w.pinned_base), span)) begin
                    base  = int'(w.pinned_base);
                    found = 1'b1;
                end
            end else if (span <= lim) begin
                align = 1;
                while (align < span) begin
                    align = align << 1;
                end
                for (int b = 0; b <= lim - span && !found; b += align) begin
                    if (!overlaps(b, span)) begin
                        base  = b;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                r.status   = ST_NOROOM;
                run_failed = 1'b1;
            end else begin
                for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
                    if (!tbl_valid[i] && slot < 0) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    r.status   = ST_OVERFLOW;
                    run_failed = 1'b1;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_base[slot]  = base;
                    tbl_span[slot]  = span;
                    tbl_end[slot]   = int'(w.live_end);
                    if (base + span > peak_regs) begin
                        peak_regs = base + span;
                    end
                    if (w.set_ident == cfg_cand) begin
                        cand_seen = 1'b1;
                    end
                    r.status      = ST_PLACED;
                    r.placed_base = BASE_W'(base);
                end
            end
        end
        r.peak_footprint = FOOT_W'(peak_regs);
        r.run_ok         = w.last_item && !run_failed && cand_seen;
        r.run_done       = w.last_item;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // shorthand for the directed intervals
    function automatic air_in_t interval(input bit first, input bit last, input int ident,
                                         input int start, input int stop, input int span,
                                         input bit pin, input int pbase);
        air_in_t w;
        w.first_item  = first;
        w.last_item   = last;
        w.set_ident   = IDENT_W'(ident);
        w.live_start  = POS_W'(start);
        w.live_end    = POS_W'(stop);
        w.span        = SPAN_W'(span);
        w.pinned      = pin;
        w.pinned_base = BASE_W'(pbase);
        return w;
    endfunction

    // a well-formed run in start order; a crowded run piles up long-lived
    // mostly zero-span intervals so the active table runs out of entries
    task automatic queue_run(input int len, input bit crowded);
        air_in_t w;
        int pos, lim, r, stop_pos;
        lim = (cfg_limit > REG_FILE_SIZE) ? REG_FILE_SIZE : cfg_limit;
        pos = $urandom_range(0, 65535);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            w.first_item = (k == 0);
            w.last_item  = (k == len - 1);
            w.set_ident  = (r < 40) ? cfg_cand :
                           (r < 85) ? IDENT_W'($urandom_range(0, 7)) : IDENT_W'($urandom);
            w.live_start = POS_W'(pos);
            if (crowded) begin
                w.span        = ($urandom_range(0, 9) < 8) ? '0 : SPAN_W'($urandom_range(1, 2));
                w.pinned      = 1'b0;
                w.pinned_base = BASE_W'($urandom);
                stop_pos      = pos + $urandom_range(2000, 65535);
                pos          += $urandom_range(0, 1);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    w.span = SPAN_W'($urandom_range(0, 8));
                end else if (r < 80) begin
                    w.span = SPAN_W'($urandom_range(9, 64));
                end else if (r < 92) begin
                    w.span = SPAN_W'($urandom_range(65, 512));
                end else if (r < 96) begin
                    w.span = SPAN_W'(512);
                end else begin
                    w.span = SPAN_W'(lim);
                end
                w.pinned      = ($urandom_range(0, 3) == 0);
                w.pinned_base = $urandom_range(0, 1) ? BASE_W'($urandom)
                                                     : BASE_W'($urandom_range(0, lim));
                // now and then an end below the start
                if ($urandom_range(0, 19) == 0 && pos > 0) begin
                    stop_pos = $urandom_range(0, pos - 1);
                end else begin
                    stop_pos = pos + $urandom_range(0, 60);
                end
                pos += $urandom_range(0, 8);
            end
            w.live_end = POS_W'((stop_pos > 65535) ? 65535 : stop_pos);
            if (pos > 65535) begin
                pos = 65535;
            end
            add_interval(w);
        end
    endtask

    // register writes go in only while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IDX_LIMIT) begin
            cfg_limit = val & 'h3FF;
        end else begin
            cfg_cand = 16'(val);
        end
    endtask

    // every word driven has come back
    task automatic wait_drained();
        while (interval_q.size() != 0 || s_valid || placement_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // driver: present the next interval once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (interval_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= interval_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on every accepted interval, check every accepted result
    always @(posedge aclk) begin : monitor
        air_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                placement_q.insert(placement_q.size(), place_interval(s_data));
            end
            if (m_valid && m_ready) begin
                if (placement_q.size() == 0) begin
                    $display("%0t mismatch: result word with none expected, actual %h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    want = placement_q.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("placed_base", want.placed_base, m_data.placed_base);
                    check_field("peak_footprint", want.peak_footprint, m_data.peak_footprint);
                    check_field("run_ok", want.run_ok, m_data.run_ok);
                    check_field("run_done", want.run_done, m_data.run_done);
                    words_checked++;
                    status_tally[want.status]++;
                    if (want.run_done) begin
                        runs_closed++;
                    end
                    if (want.run_ok) begin
                        runs_ok++;
                    end
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // per-phase register settings; phase 5 draws its own, phase 8 its own candidate
    int phase_limit[PHASES] = '{256, 512, 0, 1023, 64, 0, 1, 300, 511};
    int phase_cand[PHASES]  = '{0, 3, 65535, 5, 0, 0, 2, 7, 0};

    initial begin : stimulus
        int queued, kind, n, lim_val, cand_val;
        air_in_t w;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            lim_val  = (p == 5) ? $urandom_range(0, 512) : phase_limit[p];
            cand_val = (p == 5) ? $urandom_range(0, 7) :
                       (p == 8) ? $urandom_range(0, 65535) : phase_cand[p];
            write_reg(REG_IDX_LIMIT, lim_val);
            write_reg(REG_IDX_CAND, cand_val);
            settings_used++;

            // sender mostly busy first, then receiver mostly busy, then no idling
            send_idle_pct <= (p < 3) ? 15 : (p < 6) ? 83 : 0;
            recv_idle_pct <= (p < 3) ? 83 : (p < 6) ? 15 : 0;

            if (p == 0) begin
                // directed, limit 256 and candidate 0
                // zero span, then aligned first fit around it
                add_interval(interval(1, 0, 0, 0, 10, 0, 0, 0));
                add_interval(interval(0, 0, 1, 1, 10, 1, 0, 0));
                add_interval(interval(0, 0, 2, 2, 10, 3, 0, 0));
                // pinned fits, pinned overlap fails, then skipped to the end
                add_interval(interval(0, 0, 3, 3, 10, 4, 1, 8));
                add_interval(interval(0, 0, 4, 4, 10, 2, 1, 6));
                add_interval(interval(0, 1, 0, 5, 10, 1, 0, 0));
                // span equal to the limit, then just above it
                add_interval(interval(1, 1, 0, 0, 0, 256, 0, 0));
                add_interval(interval(1, 0, 9, 0, 0, 257, 0, 0));
                add_interval(interval(0, 1, 9, 1, 1, 1, 0, 0));
                // pinned past the limit, pinned right at its top
                add_interval(interval(1, 0, 7, 0, 5, 1, 1, 511));
                add_interval(interval(1, 0, 0, 10, 20, 1, 1, 255));
                // end below start and expiry of it
                add_interval(interval(0, 0, 0, 100, 50, 8, 0, 0));
                add_interval(interval(0, 0, 0, 101, 200, 8, 0, 0));
                add_interval(interval(0, 1, 0, 101, 200, 8, 0, 0));
                // no first item after a last one: the table carries over
                add_interval(interval(0, 0, 0, 150, 300, 16, 0, 0));
                // field extremes
                add_interval(interval(0, 1, 65535, 65535, 65535, 512, 1, 511));
                add_interval(interval(1, 0, 65535, 65535, 65535, 0, 1, 200));
                add_interval(interval(0, 1, 65535, 65535, 0, 512, 0, 0));
            end else begin
                queued = 0;
                while (queued < PHASE_WORDS) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 76) begin
                        n = $urandom_range(1, 16);
                        queue_run(n, 1'b0);
                    end else if (kind < 80) begin
                        n = $urandom_range(66, 72);
                        queue_run(n, 1'b1);
                    end else begin
                        // noise: any field value, runs broken up at random
                        n = $urandom_range(1, 6);
                        repeat (n) begin
                            w            = $bits(air_in_t)'({$urandom, $urandom, $urandom});
                            w.first_item = ($urandom_range(0, 3) == 0);
                            w.span       = SPAN_W'($urandom_range(0, 512));
                            add_interval(w);
                        end
                    end
                    queued += n;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d words checked over %0d register settings: %0d placed, %0d no room,",
                 words_checked, settings_used, status_tally[ST_PLACED], status_tally[ST_NOROOM]);
        $display("tb: %0d skipped, %0d table overflow, %0d runs closed, %0d with run_ok",
                 status_tally[ST_SKIPPED], status_tally[ST_OVERFLOW], runs_closed, runs_ok);
        if (mismatches == 0 && placement_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
